>>> sv/hjd_pkg.sv
// shared widths, sequencer states and digit code table for the lattice digit converter
`timescale 1ns / 1ps

package hjd_pkg;

    localparam int unsigned CoordW     = 26;
    localparam int unsigned WorkW      = CoordW + 1;
    localparam int unsigned DigitW     = 3;
    localparam int unsigned LevelW     = 5;
    localparam int unsigned ResW       = 5;
    localparam int unsigned MaxLevelsDef = 16;
    localparam logic [ResW-1:0] ResReset = 5'd4;

    // digits of the corrected codes
    localparam logic [DigitW-1:0] DigitZero  = 3'd0;
    localparam logic [DigitW-1:0] DigitTwo   = 3'd2;
    localparam logic [DigitW-1:0] DigitThree = 3'd3;
    localparam logic [DigitW-1:0] DigitFive  = 3'd5;
    localparam logic [DigitW-1:0] DigitSix   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_BAL,
        ST_DIV_M,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [DigitW-1:0] hi;
        logic [DigitW-1:0] lo;
    } t_code;

    // balanced remainder pair (r,s), each -2..2, to two-digit code
    function automatic t_code code_lookup(input logic signed [2:0] r,
                                          input logic signed [2:0] s);
        t_code c;
        c = '{hi: 3'd0, lo: 3'd0};
        unique case ({r, s})
            {3'sd0,  3'sd0}:  c = '{hi: 3'd0, lo: 3'd0};
            {3'sd1,  3'sd1}:  c = '{hi: 3'd0, lo: 3'd1};
            {-3'sd1, 3'sd1}:  c = '{hi: 3'd0, lo: 3'd2};
            {-3'sd2, 3'sd0}:  c = '{hi: 3'd0, lo: 3'd3};
            {-3'sd1, -3'sd1}: c = '{hi: 3'd0, lo: 3'd4};
            {3'sd1,  -3'sd1}: c = '{hi: 3'd0, lo: 3'd5};
            {3'sd2,  3'sd0}:  c = '{hi: 3'd0, lo: 3'd6};
            {3'sd0,  3'sd2}:  c = '{hi: 3'd1, lo: 3'd0};
            {3'sd0,  -3'sd2}: c = '{hi: 3'd4, lo: 3'd0};
            default:          c = '{hi: 3'd0, lo: 3'd0};
        endcase
        return c;
    endfunction

endpackage

>>> sv/hjd_in_if.sv
// input channel: one lattice cell per word
`timescale 1ns / 1ps

interface hjd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [hjd_pkg::CoordW-1:0]   j_coord;
    logic signed [hjd_pkg::CoordW-1:0]   k_coord;

    modport source (output valid, output j_coord, output k_coord, input ready);
    modport sink   (input valid, input j_coord, input k_coord, output ready);
endinterface

>>> sv/hjd_out_if.sv
// output channel: one level's digit code per word
`timescale 1ns / 1ps

interface hjd_out_if;
    logic                          valid;
    logic                          ready;
    logic [hjd_pkg::DigitW-1:0]    digit_high;
    logic [hjd_pkg::DigitW-1:0]    digit_low;
    logic [hjd_pkg::LevelW-1:0]    level;
    logic                          last;

    modport source (output valid, output digit_high, output digit_low, output level,
                    output last, input ready);
    modport sink   (input valid, input digit_high, input digit_low, input level,
                    input last, output ready);
endinterface

>>> sv/hjd_cfg_if.sv
// configuration write channel for the resolution register
`timescale 1ns / 1ps

interface hjd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [hjd_pkg::ResW-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/hex_lattice_jk_to_digit_index.sv
// top level: lattice cell (j,k) to per-level hierarchical digit codes
`timescale 1ns / 1ps

// A cell (j,k) is taken when in ready is high, which is only while no cell is in
// conversion; it then gives one output word per level, level 1 first, with last set
// on the final level (resolution, capped at MAX_LEVELS; resolution zero gives no
// words). Each level steps through the states DIV_A, DIV_B, BAL, DIV_M and EMIT: one
// shared divide-by-three multiplier is used three times per level (a, b, then the
// balanced a quotient for its residue), with a state to balance the remainders and
// one to emit, which waits while the output word is stalled. The final word
// may sit in the output register while the next cell is accepted. Resolution resets
// to 4 and is written through the configuration channel, which is always ready.
module hex_lattice_jk_to_digit_index #(
    parameter int unsigned MAX_LEVELS = hjd_pkg::MaxLevelsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hjd_in_if.sink          i_in,
    hjd_out_if.source       o_out,
    hjd_cfg_if.sink         i_cfg
);

    localparam int unsigned W  = hjd_pkg::WorkW;
    localparam int unsigned LW = hjd_pkg::LevelW;
    localparam int unsigned LvlCapI = (MAX_LEVELS > (2**LW - 1)) ? (2**LW - 1) : MAX_LEVELS;
    localparam logic [LW-1:0] LvlCap = LW'(LvlCapI);

    hjd_pkg::t_state r_state, n_state;

    logic [hjd_pkg::ResW-1:0] r_res;
    logic signed [W-1:0]      r_a, r_b, r_ap, r_bp;
    logic [1:0]               r_rraw, r_sraw, r_m;
    logic signed [2:0]        r_rb, r_sb;
    logic [LW-1:0]            r_lvl, r_levels;

    logic                       r_out_valid;
    logic [hjd_pkg::DigitW-1:0] r_dh, r_dl;
    logic [LW-1:0]              r_olvl;
    logic                       r_olast;

    logic                 in_acc, out_free;
    logic [LW-1:0]        levels;
    logic signed [W-1:0]  div_in, div_quo;
    logic [1:0]           div_rem;

    // sequencer controls
    logic ld_cell, ld_a, ld_b, ld_bal, ld_m, ld_emit;

    // balance results
    logic signed [2:0]    bal_r, bal_s;
    logic signed [W-1:0]  bal_ap, bal_bp;

    // emit results
    hjd_pkg::t_code       code;
    logic signed [W-1:0]  nxt_a, nxt_b;

    assign in_acc   = i_in.valid & i_in.ready;
    assign out_free = ~r_out_valid | o_out.ready;
    assign levels   = (LW'(r_res) > LvlCap) ? LvlCap : LW'(r_res);

    assign i_in.ready  = (r_state == hjd_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.digit_high = r_dh;
    assign o_out.digit_low  = r_dl;
    assign o_out.level      = r_olvl;
    assign o_out.last       = r_olast;

    always_comb begin
        unique case (r_state)
            hjd_pkg::ST_DIV_B: div_in = r_b;
            hjd_pkg::ST_DIV_M: div_in = r_ap;
            default:           div_in = r_a;
        endcase
    end

    hjd_div3 u_div3 (
        .i_val (div_in),
        .o_quo (div_quo),
        .o_rem (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hjd_pkg::ST_IDLE: begin
                if (in_acc && levels != '0) n_state = hjd_pkg::ST_DIV_A;
            end
            hjd_pkg::ST_DIV_A: n_state = hjd_pkg::ST_DIV_B;
            hjd_pkg::ST_DIV_B: n_state = hjd_pkg::ST_BAL;
            hjd_pkg::ST_BAL:   n_state = hjd_pkg::ST_DIV_M;
            hjd_pkg::ST_DIV_M: n_state = hjd_pkg::ST_EMIT;
            hjd_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_lvl == r_levels) ? hjd_pkg::ST_IDLE : hjd_pkg::ST_DIV_A;
                end
            end
            default: n_state = hjd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ld_cell = 1'b0;
        ld_a    = 1'b0;
        ld_b    = 1'b0;
        ld_bal  = 1'b0;
        ld_m    = 1'b0;
        ld_emit = 1'b0;
        unique case (r_state)
            hjd_pkg::ST_IDLE:  ld_cell = in_acc;
            hjd_pkg::ST_DIV_A: ld_a    = 1'b1;
            hjd_pkg::ST_DIV_B: ld_b    = 1'b1;
            hjd_pkg::ST_BAL:   ld_bal  = 1'b1;
            hjd_pkg::ST_DIV_M: ld_m    = 1'b1;
            hjd_pkg::ST_EMIT:  ld_emit = out_free;
            default: ;
        endcase
    end

    // fold remainders into the balanced pair
    always_comb begin
        bal_r  = $signed({1'b0, r_rraw});
        bal_s  = $signed({1'b0, r_sraw});
        bal_ap = r_ap;
        bal_bp = r_bp;
        priority if ({1'b0, r_sraw} == {1'b0, r_rraw} + 3'd1) begin
            bal_s  = bal_s - 3'sd3;
            bal_bp = r_bp + W'(1);
        end else if ({1'b0, r_sraw} + 3'd1 == {1'b0, r_rraw}) begin
            bal_r  = bal_r - 3'sd3;
            bal_ap = r_ap + W'(1);
        end else if (r_rraw == 2'd2 && r_sraw == 2'd2) begin
            bal_r  = -3'sd1;
            bal_s  = -3'sd1;
            bal_ap = r_ap + W'(1);
            bal_bp = r_bp + W'(1);
        end else begin
            bal_r  = $signed({1'b0, r_rraw});
        end
    end

    // code and corrected a, b for this level
    always_comb begin
        code  = hjd_pkg::code_lookup(r_rb, r_sb);
        nxt_a = r_ap;
        nxt_b = r_bp;
        priority if ((r_sb != 3'sd2 && r_sb != -3'sd2) || r_m == 2'd0) begin
            nxt_a = r_ap;
        end else if (r_sb == 3'sd2 && r_m == 2'd1) begin
            code  = '{hi: hjd_pkg::DigitFive, lo: hjd_pkg::DigitZero};
            nxt_a = r_ap - W'(1);
            nxt_b = r_bp + W'(1);
        end else if (r_sb == 3'sd2) begin
            code  = '{hi: hjd_pkg::DigitThree, lo: hjd_pkg::DigitZero};
            nxt_a = r_ap + W'(1);
            nxt_b = r_bp + W'(1);
        end else if (r_m == 2'd2) begin
            code  = '{hi: hjd_pkg::DigitTwo, lo: hjd_pkg::DigitZero};
            nxt_a = r_ap + W'(1);
            nxt_b = r_bp - W'(1);
        end else begin
            code  = '{hi: hjd_pkg::DigitSix, lo: hjd_pkg::DigitZero};
            nxt_a = r_ap - W'(1);
            nxt_b = r_bp - W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hjd_pkg::ST_IDLE;
            r_res       <= hjd_pkg::ResReset;
            r_out_valid <= 1'b0;
            r_a         <= '0;
            r_b         <= '0;
            r_lvl       <= '0;
            r_levels    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) r_res <= i_cfg.data;

            if (ld_cell && levels != '0) begin
                r_a      <= {i_in.j_coord[hjd_pkg::CoordW-1], i_in.j_coord}
                          - {i_in.k_coord[hjd_pkg::CoordW-1], i_in.k_coord};
                r_b      <= {i_in.j_coord[hjd_pkg::CoordW-1], i_in.j_coord}
                          + {i_in.k_coord[hjd_pkg::CoordW-1], i_in.k_coord};
                r_lvl    <= LW'(1);
                r_levels <= levels;
            end
            if (ld_emit) begin
                r_a <= nxt_a;
                r_b <= nxt_b;
                if (r_lvl != r_levels) r_lvl <= r_lvl + LW'(1);
            end

            if (ld_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers without reset
    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_ap   <= div_quo;
            r_rraw <= div_rem;
        end
        if (ld_b) begin
            r_bp   <= div_quo;
            r_sraw <= div_rem;
        end
        if (ld_bal) begin
            r_ap <= bal_ap;
            r_bp <= bal_bp;
            r_rb <= bal_r;
            r_sb <= bal_s;
        end
        if (ld_m) r_m <= div_rem;
        if (ld_emit) begin
            r_dh    <= code.hi;
            r_dl    <= code.lo;
            r_olvl  <= r_lvl;
            r_olast <= (r_lvl == r_levels);
        end
    end

endmodule

>>> sv/hjd_div3.sv
// signed floor division by three with remainder 0..2, via reciprocal multiply
`timescale 1ns / 1ps

module hjd_div3 (
    input  logic signed [hjd_pkg::WorkW-1:0] i_val,
    output logic signed [hjd_pkg::WorkW-1:0] o_quo,
    output logic        [1:0]                o_rem
);

    localparam int unsigned W  = hjd_pkg::WorkW;
    localparam int unsigned UW = W + 1;
    localparam int unsigned PW = UW + 32;
    // offset is a multiple of three, so flooring commutes with it
    localparam logic [UW-1:0] Offset = UW'(3) << (W - 2);
    localparam logic [UW-1:0] QOff   = UW'(1) << (W - 2);
    localparam logic [31:0]   Recip  = 32'hAAAA_AAAB;

    logic [UW-1:0] u;
    logic [PW-1:0] prod;
    logic [W-1:0]  qu;
    logic [UW-1:0] rem_full;
    logic [UW-1:0] q_full;

    assign u        = {i_val[W-1], i_val} + Offset;
    assign prod     = PW'(u) * PW'(Recip);
    assign qu       = prod[W+32:33];
    assign rem_full = u - ({1'b0, qu} + {qu, 1'b0});
    assign q_full   = {1'b0, qu} - QOff;
    assign o_rem    = rem_full[1:0];
    assign o_quo    = $signed(q_full[W-1:0]);

endmodule

>>> sv/hjd_checker.sv
// port-level checks for the lattice digit converter, bound to the top level
`timescale 1ns / 1ps

module hjd_checker #(
    parameter int unsigned MAX_LEVELS = hjd_pkg::MaxLevelsDef
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [hjd_pkg::DigitW-1:0]    i_digit_high,
    input logic [hjd_pkg::DigitW-1:0]    i_digit_low,
    input logic [hjd_pkg::LevelW-1:0]    i_level,
    input logic                          i_last,
    input logic                          i_cfg_valid,
    input logic                          i_cfg_ready,
    input logic [hjd_pkg::ResW-1:0]      i_cfg_data
);

    localparam int unsigned LW = hjd_pkg::LevelW;
    localparam int unsigned LvlCapI = (MAX_LEVELS > (2**LW - 1)) ? (2**LW - 1) : MAX_LEVELS;
    localparam logic [LW-1:0] LvlCap = LW'(LvlCapI);

    logic [hjd_pkg::ResW-1:0] r_res;
    logic [LW-1:0]            cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= hjd_pkg::ResReset;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_res <= i_cfg_data;
        end
    end

    assign cap = (LW'(r_res) > LvlCap) ? LvlCap : LW'(r_res);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_level)
            && $stable(i_digit_high) && $stable(i_digit_low) && $stable(i_last))
        else $error("stalled output word changed");

    // a cell with levels to convert makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && cap != '0 |=> !i_in_ready)
        else $error("input taken while a cell was in conversion");

    // digits and level stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_digit_high <= 3'd6 && i_digit_low <= 3'd6 && i_level != '0)
        else $error("output word out of range");

    // final level matches the capped resolution
    a_last_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> i_level == cap)
        else $error("last flag on wrong level");

endmodule

bind hex_lattice_jk_to_digit_index hjd_checker #(.MAX_LEVELS(MAX_LEVELS)) u_hjd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_digit_high (o_out.digit_high),
    .i_digit_low  (o_out.digit_low),
    .i_level      (o_out.level),
    .i_last       (o_out.last),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_cfg_data   (i_cfg.data)
);

>>> verif/tb.sv
// testbench for the lattice cell to digit index converter: directed, random and stall tests
`timescale 1ns / 1ps

module tb;

    localparam int CoordW        = hjd_pkg::CoordW;
    localparam int DigitW        = hjd_pkg::DigitW;
    localparam int LevelW        = hjd_pkg::LevelW;
    localparam int ResW          = hjd_pkg::ResW;
    localparam int MaxLevels     = hjd_pkg::MaxLevelsDef;
    localparam int WatchdogLimit = 5000;
    localparam int HoldCycles    = 400;
    // quiet margin after the last due word so that a stray extra word is still caught
    localparam int SettleCycles  = 5 * MaxLevels + 10;
    localparam int CoordBound    = 21523360;

    typedef struct packed {
        logic [DigitW-1:0] hi;
        logic [DigitW-1:0] lo;
        logic [LevelW-1:0] level;
        logic              last;
    } t_level_word;

    logic clk;
    logic rst_n;

    hjd_in_if  in_ch ();
    hjd_out_if out_ch ();
    hjd_cfg_if cfg_ch ();

    hex_lattice_jk_to_digit_index uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_level_word     due_words[$];
    t_level_word     head_word;
    logic [ResW-1:0] resolution;
    int              mismatches;
    int              cells_sent;
    int              words_seen;
    int              res_writes;
    int              hold_requests;
    int              hold_served;
    int              rx_hold;
    bit              tx_gaps;
    bit              rx_gaps;
    int              quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic div3_floor(input longint v, output longint q, output longint rem);
        q   = v / 3;
        rem = v % 3;
        if (rem < 0) begin
            rem += 3;
            q   -= 1;
        end
    endtask

    // queue up the level words that one accepted cell must produce
    task automatic predict_digits(input logic signed [CoordW-1:0] j_in,
                                  input logic signed [CoordW-1:0] k_in);
        longint          a, b, qa, qb, ra, rb, m;
        int              levels;
        logic [2:0]      r3, s3;
        logic [5:0]      pair;
        t_level_word     w;
        a = longint'(j_in) - longint'(k_in);
        b = longint'(j_in) + longint'(k_in);
        levels = (int'(resolution) > MaxLevels) ? MaxLevels : int'(resolution);
        for (int lv = 1; lv <= levels; lv++) begin
            div3_floor(a, qa, ra);
            div3_floor(b, qb, rb);
            if (rb == ra + 1) begin
                rb -= 3;
                qb += 1;
            end else if (rb == ra - 1) begin
                ra -= 3;
                qa += 1;
            end else if (ra == 2 && rb == 2) begin
                ra = -1;
                rb = -1;
                qa += 1;
                qb += 1;
            end
            m = qa % 3;
            if (m < 0)
                m += 3;
            w.level = LevelW'(lv);
            w.last  = (lv == levels);
            if ((rb != 2 && rb != -2) || m == 0) begin
                r3 = ra[2:0];
                s3 = rb[2:0];
                // octal pair: high digit, low digit
                case ({r3, s3})
                    {3'sd0,  3'sd0}:  pair = 6'o00;
                    {3'sd1,  3'sd1}:  pair = 6'o01;
                    {-3'sd1, 3'sd1}:  pair = 6'o02;
                    {-3'sd2, 3'sd0}:  pair = 6'o03;
                    {-3'sd1, -3'sd1}: pair = 6'o04;
                    {3'sd1,  -3'sd1}: pair = 6'o05;
                    {3'sd2,  3'sd0}:  pair = 6'o06;
                    {3'sd0,  3'sd2}:  pair = 6'o10;
                    {3'sd0,  -3'sd2}: pair = 6'o40;
                    default:          pair = 6'o00;
                endcase
                {w.hi, w.lo} = pair;
                a = qa;
                b = qb;
            end else if (rb == 2 && m == 1) begin
                w.hi = hjd_pkg::DigitFive;
                w.lo = hjd_pkg::DigitZero;
                a = qa - 1;
                b = qb + 1;
            end else if (rb == 2) begin
                w.hi = hjd_pkg::DigitThree;
                w.lo = hjd_pkg::DigitZero;
                a = qa + 1;
                b = qb + 1;
            end else if (m == 2) begin
                w.hi = hjd_pkg::DigitTwo;
                w.lo = hjd_pkg::DigitZero;
                a = qa + 1;
                b = qb - 1;
            end else begin
                w.hi = hjd_pkg::DigitSix;
                w.lo = hjd_pkg::DigitZero;
                a = qa - 1;
                b = qb - 1;
            end
            due_words.push_back(w);
        end
    endtask

    // valid stays up across back-to-back cells; it only drops in a gap or when settling
    task automatic send_cell(input logic signed [CoordW-1:0] j_in,
                             input logic signed [CoordW-1:0] k_in);
        while (tx_gaps && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.j_coord <= j_in;
        in_ch.k_coord <= k_in;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_digits(j_in, k_in);
        cells_sent++;
    endtask

    task automatic settle_block();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_resolution(input logic [ResW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        resolution = value;
        res_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [CoordW-1:0] coord(input int v);
        return CoordW'(v);
    endfunction

    function automatic logic signed [CoordW-1:0] pick_coord();
        int sel;
        sel = $urandom_range(3);
        if (sel < 2)
            return CoordW'($urandom());
        else if (sel == 2)
            return CoordW'(int'($urandom_range(2 * CoordBound)) - CoordBound);
        return CoordW'(int'($urandom_range(80)) - 40);
    endfunction

    function automatic logic [ResW-1:0] pick_resolution();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 5)
            return ResW'($urandom_range(4, 1));
        else if (sel == 6)
            return '0;
        else if (sel == 7)
            return ResW'(MaxLevels);
        else if (sel == 8)
            return ResW'($urandom_range(31, MaxLevels + 1));
        return ResW'($urandom_range(MaxLevels - 1, 5));
    endfunction

    // reset resolution, coordinate extremes and small cells
    task automatic test_coord_extremes();
        logic signed [CoordW-1:0] hi_c, lo_c;
        hi_c = {1'b0, {(CoordW-1){1'b1}}};
        lo_c = {1'b1, {(CoordW-1){1'b0}}};
        send_cell(coord(0), coord(0));
        send_cell(hi_c, hi_c);
        send_cell(lo_c, lo_c);
        send_cell(hi_c, lo_c);
        send_cell(lo_c, hi_c);
        send_cell(coord(CoordBound), coord(-CoordBound));
        send_cell(coord(-CoordBound), coord(CoordBound));
        send_cell(coord(CoordBound), coord(CoordBound));
        send_cell(coord(1), coord(0));
        send_cell(coord(0), coord(-1));
        send_cell(coord(2), coord(1));
        settle_block();
    endtask

    // full depth, saturation above the cap, zero levels, single level
    task automatic test_resolution_extremes();
        write_resolution(ResW'(MaxLevels));
        send_cell(coord(-CoordBound), coord(-CoordBound + 7));
        send_cell(coord(12345), coord(-678));
        settle_block();
        write_resolution('1);
        send_cell(coord(CoordBound), coord(1));
        send_cell(coord(-5), coord(3));
        settle_block();
        write_resolution('0);
        send_cell(coord(7), coord(7));
        send_cell(coord(-CoordBound), coord(0));
        settle_block();
        write_resolution(ResW'(1));
        send_cell(coord(-1), coord(-1));
        send_cell(coord(4), coord(-2));
        settle_block();
    endtask

    task automatic test_random_cells();
        for (int phase = 0; phase < 8; phase++) begin
            // one phase runs with both sides always ready
            tx_gaps = (phase != 3);
            rx_gaps = (phase != 3);
            write_resolution(pick_resolution());
            for (int n = 0; n < 12; n++)
                send_cell(pick_coord(), pick_coord());
            settle_block();
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // receiver holds off while cells keep coming, then the sender waits for the drain
    task automatic test_output_backpressure();
        write_resolution(ResW'(3));
        @(posedge clk);
        hold_requests++;
        tx_gaps = 1'b0;
        for (int n = 0; n < 6; n++)
            send_cell(pick_coord(), pick_coord());
        tx_gaps = 1'b1;
        settle_block();
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            rx_hold      = 0;
            hold_served  = hold_requests;
        end else if (hold_requests != hold_served) begin
            hold_served  = hold_requests;
            rx_hold      = HoldCycles - 1;
            out_ch.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            out_ch.ready <= 1'b0;
            rx_hold--;
        end else begin
            out_ch.ready <= !(rx_gaps && $urandom_range(99) < 29);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            words_seen++;
            if (due_words.size() == 0) begin
                report_mismatch("word with none due, level", int'(out_ch.level), 0);
            end else begin
                head_word = due_words.pop_front();
                if (out_ch.digit_high !== head_word.hi)
                    report_mismatch("digit_high", int'(out_ch.digit_high),
                                    int'(head_word.hi));
                if (out_ch.digit_low !== head_word.lo)
                    report_mismatch("digit_low", int'(out_ch.digit_low),
                                    int'(head_word.lo));
                if (out_ch.level !== head_word.level)
                    report_mismatch("level", int'(out_ch.level), int'(head_word.level));
                if (out_ch.last !== head_word.last)
                    report_mismatch("last", int'(out_ch.last), int'(head_word.last));
            end
        end
    end

    initial begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < WatchdogLimit) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d cycles with no word moving", WatchdogLimit);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.j_coord = '0;
        in_ch.k_coord = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        resolution    = hjd_pkg::ResReset;
        mismatches    = 0;
        cells_sent    = 0;
        words_seen    = 0;
        res_writes    = 0;
        hold_requests = 0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coord_extremes();
        test_resolution_extremes();
        test_random_cells();
        test_output_backpressure();

        if (due_words.size() != 0)
            report_mismatch("words still due at end", 0, due_words.size());
        $display("sent %0d cells and checked %0d level words over %0d resolution writes",
                 cells_sent, words_seen, res_writes);
        $display("covered zero, single, full and saturated depth, random gaps and a long stall");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/hjd_pkg.sv
sv/hjd_in_if.sv
sv/hjd_out_if.sv
sv/hjd_cfg_if.sv
sv/hjd_div3.sv
sv/hex_lattice_jk_to_digit_index.sv
sv/hjd_checker.sv
verif/tb.sv
